@@ src/utf8_to_utf16_transcoder_defines.svh @@
// Assertion macros for the UTF-8 to UTF-16 transcoder.
// Included by the top level only; needs no other file.
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define UTT_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("transcoder check failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define UTT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("transcoder check failed");
`else
`define UTT_ASSERT_SAME(label, clk, rstn, ante, cons)
`define UTT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ src/utt_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; used by utt_decode, utt_emit and the top level.
package utt_pkg;

    localparam logic [15:0] REPL_UNIT  = 16'hFFFD;
    localparam logic [15:0] HI_SURR    = 16'hD800;
    localparam logic [15:0] LO_SURR    = 16'hDC00;
    localparam logic [20:0] PLANE1     = 21'h10000;
    localparam logic [20:0] BMP_MAX    = 21'h0FFFF;
    localparam int          MAX_UNITS  = 4;

    // Up to four code units produced by one input word, first unit in slot 0.
    typedef struct packed {
        logic [2:0]                  count;
        logic [MAX_UNITS-1:0][15:0]  units;
    } bundle_t;

    // Sequence tracking state seen by the top level checks.
    typedef struct packed {
        logic [1:0] remaining;
        logic [1:0] taken;
    } dec_status_t;

endpackage

@@ src/utt_decode.sv @@
// Decoder: sequence state registers and the per-byte decode logic.
// Depends on utt_pkg.
module utt_decode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 consume,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_text,
    output utt_pkg::bundle_t     bundle,
    output utt_pkg::dec_status_t status
);

    logic [20:0] point_reg, point_next;
    logic [1:0]  remaining_reg, remaining_next;
    logic [1:0]  taken_reg, taken_next;

    logic        pending;
    logic        is_cont;
    logic [20:0] joined;
    logic [20:0] offset;
    logic [15:0] hi_unit;
    logic [15:0] lo_unit;
    logic [2:0]  flush_cnt;
    logic        lead_emit;
    logic [15:0] lead_unit;

    assign pending = (remaining_reg != 2'd0);
    assign is_cont = !end_of_text && (data_byte[7:6] == 2'b10);
    assign joined  = {point_reg[14:0], data_byte[5:0]};
    assign offset  = joined - utt_pkg::PLANE1;
    assign hi_unit = utt_pkg::HI_SURR + {5'd0, offset[20:10]};
    assign lo_unit = utt_pkg::LO_SURR + {6'd0, offset[9:0]};
    assign flush_cnt = pending ? ({1'b0, taken_reg} + 3'd1) : 3'd0;

    always_comb begin
        point_next     = point_reg;
        remaining_next = remaining_reg;
        taken_next     = taken_reg;
        lead_emit      = 1'b0;
        lead_unit      = utt_pkg::REPL_UNIT;
        bundle.count   = 3'd0;
        bundle.units   = '0;

        if (pending && is_cont) begin
            point_next     = joined;
            taken_next     = taken_reg + 2'd1;
            remaining_next = remaining_reg - 2'd1;
            if (remaining_reg == 2'd1) begin
                point_next     = '0;
                taken_next     = 2'd0;
                remaining_next = 2'd0;
                if (joined > utt_pkg::BMP_MAX) begin
                    bundle.count    = 3'd2;
                    bundle.units[0] = hi_unit;
                    bundle.units[1] = lo_unit;
                end else begin
                    bundle.count    = 3'd1;
                    bundle.units[0] = joined[15:0];
                end
            end
        end else begin
            // A broken or flushed sequence clears the state before the lead byte.
            point_next     = '0;
            taken_next     = 2'd0;
            remaining_next = 2'd0;
            if (!end_of_text) begin
                priority if (data_byte[7] == 1'b0) begin
                    lead_emit = 1'b1;
                    lead_unit = {8'd0, data_byte};
                end else if (data_byte[7:5] == 3'b110) begin
                    point_next     = {16'd0, data_byte[4:0]};
                    remaining_next = 2'd1;
                end else if (data_byte[7:4] == 4'b1110) begin
                    point_next     = {17'd0, data_byte[3:0]};
                    remaining_next = 2'd2;
                end else if (data_byte[7:3] == 5'b11110) begin
                    point_next     = {18'd0, data_byte[2:0]};
                    remaining_next = 2'd3;
                end else begin
                    lead_emit = 1'b1;
                end
            end
            bundle.count = flush_cnt + {2'd0, lead_emit};
            for (int k = 0; k < utt_pkg::MAX_UNITS; k++) begin
                bundle.units[k] = (3'(k) < flush_cnt) ? utt_pkg::REPL_UNIT : lead_unit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_reg     <= '0;
            remaining_reg <= 2'd0;
            taken_reg     <= 2'd0;
        end else if (consume) begin
            point_reg     <= point_next;
            remaining_reg <= remaining_next;
            taken_reg     <= taken_next;
        end
    end

    assign status.remaining = remaining_reg;
    assign status.taken     = taken_reg;

endmodule

@@ src/utt_emit.sv @@
// Result register: holds one decoded bundle and sends its units one per cycle while m_tready is high.
// Depends on utt_pkg.
module utt_emit (
    input  logic             aclk,
    input  logic             aresetn,
    input  utt_pkg::bundle_t bundle,
    input  logic             load,
    output logic             bundle_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,
    output logic             m_tlast
);

    logic [utt_pkg::MAX_UNITS-1:0][15:0] units_reg;
    logic [2:0] count_reg;
    logic [1:0] idx_reg;
    logic       take;
    logic       last_take;

    assign m_tvalid     = (count_reg != 3'd0);
    assign m_tdata      = units_reg[idx_reg];
    assign m_tlast      = (({1'b0, idx_reg} + 3'd1) == count_reg);
    assign take         = m_tvalid && m_tready;
    assign last_take    = take && m_tlast;
    assign bundle_ready = !m_tvalid || last_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
            idx_reg   <= 2'd0;
        end else if (bundle_ready) begin
            if (load) begin
                count_reg <= bundle.count;
                idx_reg   <= 2'd0;
            end else begin
                count_reg <= 3'd0;
            end
        end else if (take) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (bundle_ready && load) begin
            units_reg <= bundle.units;
        end
    end

endmodule

@@ src/utf8_to_utf16_transcoder.sv @@
// Top level of the UTF-8 to UTF-16 transcoder: input buffer, decoder, emitter.
// Depends on utt_pkg, utt_decode, utt_emit and utf8_to_utf16_transcoder_defines.svh.
//
// Usage: UTF-8 text enters one byte per word on the s_ channel; s_tlast high marks
// the end of text, which flushes a pending partial sequence (s_tdata is then ignored).
// The m_ channel returns UTF-16 code units, one per word, with m_tlast high on the
// final unit caused by one input word. A word may cause no unit (lead and middle
// bytes of a sequence, or an end of text with nothing pending) or up to four.
// Two register stages: a word is decoded from the input register, and its units are
// loaded into the output register when the output is free and then shown on m_.
// Throughput: one input word per cycle while each word yields at most one unit and
// the receiver is ready; a word yielding several units occupies the output until
// each of them is taken, as set by the single unit-wide output port. s_tready comes
// from a register: a two-entry input buffer absorbs the word in flight when the
// output stalls, so the receiver's m_tready never reaches s_tready through logic.
// When the receiver stalls, the current unit holds on m_ and input is taken until
// the buffer is full.
// Reset (aresetn low, synchronous) empties all buffers and clears any partial
// sequence; the block is ready for input as soon as reset is released.
`include "utf8_to_utf16_transcoder_defines.svh"

module utf8_to_utf16_transcoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tlast    // last_of_run
);

    // Main input register feeds the decoder; the skid register catches the
    // word that arrives while the main register cannot be freed.
    logic       main_valid_reg;
    logic [7:0] main_byte_reg;
    logic       main_eot_reg;
    logic       skid_valid_reg;
    logic [7:0] skid_byte_reg;
    logic       skid_eot_reg;

    logic                 s_fire;
    logic                 bundle_ready;
    logic                 consume;
    utt_pkg::bundle_t     bundle;
    utt_pkg::dec_status_t status;

    assign s_tready = !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign consume  = main_valid_reg && bundle_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || consume) begin
            // The main register frees up: refill from the skid first, as it is older.
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= s_fire;
            end
        end else if (s_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || consume) begin
            if (skid_valid_reg) begin
                main_byte_reg <= skid_byte_reg;
                main_eot_reg  <= skid_eot_reg;
            end else begin
                main_byte_reg <= s_tdata;
                main_eot_reg  <= s_tlast;
            end
        end else if (s_fire) begin
            skid_byte_reg <= s_tdata;
            skid_eot_reg  <= s_tlast;
        end
    end

    utt_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .consume     (consume),
        .data_byte   (main_byte_reg),
        .end_of_text (main_eot_reg),
        .bundle      (bundle),
        .status      (status)
    );

    // Words that produce no unit are consumed without loading the emitter.
    utt_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .bundle       (bundle),
        .load         (consume && (bundle.count != 3'd0)),
        .bundle_ready (bundle_ready),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    // A run of units that has not reached its last unit keeps the output valid.
    `UTT_ASSERT_NEXT(a_run_continues, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid)
    // The skid register only fills behind an occupied main register.
    `UTT_ASSERT_SAME(a_skid_behind_main, aclk, aresetn, skid_valid_reg, main_valid_reg)
    // A sequence never expects and holds more than three continuation bytes.
    `UTT_ASSERT_SAME(a_seq_bound, aclk, aresetn, 1'b1,
        ({1'b0, status.remaining} + {1'b0, status.taken}) <= 3'd3)

endmodule

@@ dv/tb_utf8_to_utf16_transcoder.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for utf8_to_utf16_transcoder: a directed table, then random UTF-8 text.
// Depends on utt_pkg and the transcoder RTL; units are checked against the decoder or typed rows.
module tb_utf8_to_utf16_transcoder;

    // Random words sent under each of the three idling profiles.
    localparam int RAND_PER_PHASE = 85;
    // Quiet cycles after the last expected unit, well past the latency.
    localparam int DRAIN_CYCLES   = 20;
    localparam int DRAIN_GUARD    = 20000;
    localparam int MAX_REPORTS    = 10;

    // Byte classification used by the decoder.
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] ASCII_TOP = 8'h80;

    // One row of stimulus. When typed is set, the expected units are spelled out
    // in the row itself (n_units of them, first in units[0]); otherwise the
    // decoder below supplies them.
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             end_of_text;
        logic             typed;
        logic [2:0]       n_units;
        logic [3:0][15:0] units;
    } text_row_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_of_run;
    } unit_word_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // Decoder state: payload bits gathered so far and the continuation counts.
    logic [20:0] seq_point;
    logic [1:0]  seq_needed;
    logic [1:0]  seq_taken;

    text_row_t   text_rows[$];
    logic [15:0] decoded_units[$];
    unit_word_t  pending_units[$];

    int          n_directed;
    int          send_idle_pct = 37;
    int          recv_idle_pct = 56;
    int          mismatches = 0;

    utf8_to_utf16_transcoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic clear_seq();
        seq_point  = '0;
        seq_needed = '0;
        seq_taken  = '0;
    endtask

    // A finished code point: one unit inside the BMP, else a surrogate pair.
    // Points above 0x10FFFF are split the same way; the offset wraps at 21 bits.
    task automatic emit_point(input logic [20:0] cp);
        logic [20:0] offset;
        if (cp <= utt_pkg::BMP_MAX) begin
            decoded_units.push_back(cp[15:0]);
        end else begin
            offset = cp - utt_pkg::PLANE1;
            decoded_units.push_back(utt_pkg::HI_SURR + {5'b0, offset[20:10]});
            decoded_units.push_back(utt_pkg::LO_SURR + {6'b0, offset[9:0]});
        end
    endtask

    // Decodes one input word into decoded_units and advances the decoder state.
    task automatic decode_word(input logic [7:0] b, input logic eot);
        int i;
        decoded_units.delete();
        if (seq_needed != 0) begin
            if (!eot && (b & CONT_MASK) == CONT_TAG) begin
                seq_point  = {seq_point[14:0], b[5:0]};
                seq_taken  = seq_taken + 2'd1;
                seq_needed = seq_needed - 2'd1;
                if (seq_needed == 0) begin
                    emit_point(seq_point);
                    clear_seq();
                end
                return;
            end
            // The sequence is broken or flushed: one replacement for the lead
            // byte and one for every continuation byte taken so far.
            decoded_units.push_back(utt_pkg::REPL_UNIT);
            for (i = 0; i < seq_taken; i++) begin
                decoded_units.push_back(utt_pkg::REPL_UNIT);
            end
            clear_seq();
        end
        if (eot) begin
            return;
        end
        // The current byte now counts as a fresh lead byte.
        if (b < ASCII_TOP) begin
            decoded_units.push_back({8'h00, b});
        end else if (b[7:5] == 3'b110) begin
            seq_point  = {16'b0, b[4:0]};
            seq_needed = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            seq_point  = {17'b0, b[3:0]};
            seq_needed = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            seq_point  = {18'b0, b[2:0]};
            seq_needed = 2'd3;
        end else begin
            // Stray continuation byte or a lead byte from F8 up.
            decoded_units.push_back(utt_pkg::REPL_UNIT);
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic eot, input logic typed = 1'b0,
                           input logic [2:0] n = 3'd0, input logic [3:0][15:0] u = '0);
        text_rows.push_back({b, eot, typed, n, u});
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    // Lead byte of a sequence of len bytes (2 to 4) with random payload bits.
    function automatic logic [7:0] lead_byte(input int len);
        case (len)
            2:       return {3'b110, 5'($urandom_range(0, 31))};
            3:       return {4'b1110, 4'($urandom_range(0, 15))};
            default: return {5'b11110, 3'($urandom_range(0, 7))};
        endcase
    endfunction

    // Random text: mostly well-formed characters of every length with random
    // payload, plus stray bytes, broken sequences and end-of-text markers.
    task automatic gen_text(input int count);
        int target;
        int len;
        int taken;
        int i;
        int pick;
        int v;
        target = text_rows.size() + count;
        while (text_rows.size() < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 4) begin
                add_row(8'($urandom_range(0, 127)), 1'b0);
            end else if (pick < 14) begin
                // Well-formed sequence; the length leans toward two bytes.
                len = (pick < 8) ? 2 : (pick < 11) ? 3 : 4;
                add_row(lead_byte(len), 1'b0);
                for (i = 1; i < len; i++) begin
                    add_row(cont_byte(), 1'b0);
                end
            end else if (pick == 14) begin
                v = $urandom_range(0, 71);
                add_row((v < 64) ? 8'(8'h80 + v) : 8'(8'hF8 + v - 64), 1'b0);
            end else if (pick < 18) begin
                // Sequence cut short by a non-continuation byte or by end of text.
                len   = $urandom_range(2, 4);
                taken = $urandom_range(0, len - 2);
                add_row(lead_byte(len), 1'b0);
                for (i = 0; i < taken; i++) begin
                    add_row(cont_byte(), 1'b0);
                end
                if ($urandom_range(0, 1) == 0) begin
                    add_row(8'($urandom_range(0, 255)), 1'b1);
                end else begin
                    v = $urandom_range(0, 191);
                    add_row((v < 128) ? 8'(v) : 8'(v + 64), 1'b0);
                end
            end else begin
                add_row(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    // Directed table. Rows with their units typed in carry them; the rest are
    // left to the decoder.
    task automatic build_table();
        // Zero byte is an ordinary character, 7F the top of ASCII.
        add_row(8'h00, 1'b0, 1'b1, 3'd1, {48'h0, 16'h0000});
        add_row(8'h7F, 1'b0, 1'b1, 3'd1, {48'h0, 16'h007F});
        // End of text with nothing pending gives nothing.
        add_row(8'h00, 1'b1, 1'b1, 3'd0);
        // Invalid lead bytes.
        add_row(8'h80, 1'b0, 1'b1, 3'd1, {48'h0, utt_pkg::REPL_UNIT});
        add_row(8'hF8, 1'b0, 1'b1, 3'd1, {48'h0, utt_pkg::REPL_UNIT});
        add_row(8'hFF, 1'b0, 1'b1, 3'd1, {48'h0, utt_pkg::REPL_UNIT});
        // Two-byte character; the lead byte alone gives nothing.
        add_row(8'hC2, 1'b0, 1'b1, 3'd0);
        add_row(8'hA9, 1'b0);
        // Three-byte character.
        add_row(8'hE2, 1'b0);
        add_row(8'h82, 1'b0);
        add_row(8'hAC, 1'b0);
        // Four-byte character giving a surrogate pair.
        add_row(8'hF0, 1'b0);
        add_row(8'h9F, 1'b0);
        add_row(8'h98, 1'b0);
        add_row(8'h80, 1'b0);
        // Point above 0x10FFFF, still split into a pair.
        add_row(8'hF7, 1'b0);
        add_row(8'hBF, 1'b0);
        add_row(8'hBF, 1'b0);
        add_row(8'hBF, 1'b0);
        // Broken sequence: the breaking byte is then decoded as a new character.
        add_row(8'hE2, 1'b0);
        add_row(8'h82, 1'b0);
        add_row(8'h41, 1'b0);
        // End of text flushes a four-byte sequence with two continuations taken:
        // one replacement for the lead byte and one for each continuation. The
        // data byte beside the marker is ignored.
        add_row(8'hF0, 1'b0);
        add_row(8'h90, 1'b0);
        add_row(8'h80, 1'b0);
        add_row(8'hFF, 1'b1, 1'b1, 3'd3, {16'h0, {3{utt_pkg::REPL_UNIT}}});
    endtask

    // Result side: the receiver stalls at random, and each accepted word is
    // compared with the oldest expected unit.
    always @(posedge aclk) begin
        unit_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_units.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected word: code_unit %h last_of_run %b", m_tdata, m_tlast);
                end
            end else begin
                want = pending_units.pop_front();
                if (m_tdata !== want.code_unit || m_tlast !== want.last_of_run) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: expected code_unit %h last_of_run %b, got %h %b",
                                 want.code_unit, want.last_of_run, m_tdata, m_tlast);
                    end
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Input side: reset, then every row of the table and the random text, with
    // the expected units queued as each word is accepted.
    initial begin
        int idx;
        int k;
        int guard;
        text_row_t row;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        aresetn  <= 1'b0;
        clear_seq();
        build_table();
        n_directed = text_rows.size();
        gen_text(3 * RAND_PER_PHASE);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (idx = 0; idx < text_rows.size(); idx++) begin
            // First the sender idles less than the receiver, then the reverse,
            // and the last third runs with no idling at all.
            if (idx < n_directed + RAND_PER_PHASE) begin
                send_idle_pct = 37;
                recv_idle_pct = 56;
            end else if (idx < n_directed + 2 * RAND_PER_PHASE) begin
                send_idle_pct = 56;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            row = text_rows[idx];
            while ($urandom_range(0, 99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= row.data_byte;
            s_tlast  <= row.end_of_text;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);

            // The word was taken at this edge: predict its units. The decoder
            // always runs so that its state follows the text, but a typed row
            // supplies its own units.
            decode_word(row.data_byte, row.end_of_text);
            if (row.typed) begin
                decoded_units.delete();
                for (k = 0; k < row.n_units; k++) begin
                    decoded_units.push_back(row.units[k]);
                end
            end
            for (k = 0; k < decoded_units.size(); k++) begin
                pending_units.push_back({decoded_units[k], 1'(k == decoded_units.size() - 1)});
            end
        end
        s_tvalid <= 1'b0;

        guard = 0;
        while (pending_units.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        // Any word showing up in this window is flagged by the result side.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_units.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run of about 280 words.
    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

endmodule
